/* src/ats_pkg.sv */
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, widths and constants for the ATR ratchet trailing stop core.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    // field widths
    localparam int PRICE_W   = 32;
    localparam int STOP_W    = 34;
    localparam int WEIGHT_W  = 16;
    localparam int FACTOR_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // smoother chain: true range enters in Q24.16
    localparam int SMOOTH_STAGES = 6;
    localparam int FRAC_EXT      = 8;
    localparam int STAGE_W       = PRICE_W + FRAC_EXT;
    localparam int STAGE_CNT_W   = $clog2(SMOOTH_STAGES);
    localparam int DIFF_W        = STAGE_W + 1;
    localparam int PROD_W        = DIFF_W + WEIGHT_W + 1;

    // t3 combination with b = 0.5, scaled by 8
    localparam int T3_K_OUTER = 27;
    localparam int T3_K_INNER = 9;
    localparam int T3_TAP     = SMOOTH_STAGES - 4;
    localparam int T3_W       = STAGE_W + 7;
    localparam int T3_SHIFT   = 11;
    localparam int RNG_WIDE_W = T3_W - T3_SHIFT;

    // offset = range * factor in Q4.12
    localparam int OFF_SHIFT  = 12;
    localparam int OFF_PROD_W = PRICE_W + FACTOR_W;
    localparam int OFF_W      = OFF_PROD_W + 1 - OFF_SHIFT;
    localparam int SUM_W      = OFF_W + 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 2'd2;

    // register reset values
    localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST   = 16'd13107;
    localparam logic [FACTOR_W-1:0] RANGE_FACTOR_RST = 16'd10240;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_MUL,
        ST_ACC,
        ST_T3_DIFF,
        ST_T3_SUM,
        ST_CLAMP,
        ST_OFF_MUL,
        ST_OFF_ROUND,
        ST_STOP,
        ST_OUT
    } t_ats_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic range;
        logic mul;
        logic acc;
        logic t3_diff;
        logic t3_sum;
        logic clamp;
        logic off_mul;
        logic off_round;
        logic stop;
        logic out_load;
    } t_ats_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_start;
    } t_ats_status;

    // clamp a wide signed sum into the stop range
    function automatic logic signed [STOP_W-1:0] sat_stop(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:STOP_W-1] == '0) || (v[SUM_W-1:STOP_W-1] == '1);
        if (fits) begin
            sat_stop = v[STOP_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_stop = {1'b1, {(STOP_W-1){1'b0}}};
        end else begin
            sat_stop = {1'b0, {(STOP_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

/* src/ats_ctrl.sv */
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer for one bar: range, six smoother steps, t3, offset, stops, output.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_ctrl
    import ats_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_ats_status i_status,
    output t_ats_cmd         o_cmd
);

    localparam logic [STAGE_CNT_W-1:0] CNT_LAST = STAGE_CNT_W'(SMOOTH_STAGES - 1);

    t_ats_state              r_state, n_state;
    logic [STAGE_CNT_W-1:0]  r_cnt, n_cnt;
    logic                    r_out_valid;
    logic                    w_out_free;

    // output register can take a new result
    assign w_out_free = !r_out_valid || i_out_ready;

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RANGE;
            end
            ST_RANGE: begin
                n_cnt   = '0;
                n_state = i_status.is_start ? ST_T3_DIFF : ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_T3_DIFF;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_T3_DIFF:   n_state = ST_T3_SUM;
            ST_T3_SUM:    n_state = ST_CLAMP;
            ST_CLAMP:     n_state = i_status.is_start ? ST_OUT : ST_OFF_MUL;
            ST_OFF_MUL:   n_state = ST_OFF_ROUND;
            ST_OFF_ROUND: n_state = ST_STOP;
            ST_STOP:      n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RANGE:     o_cmd.range     = 1'b1;
            ST_MUL:       o_cmd.mul       = 1'b1;
            ST_ACC:       o_cmd.acc       = 1'b1;
            ST_T3_DIFF:   o_cmd.t3_diff   = 1'b1;
            ST_T3_SUM:    o_cmd.t3_sum    = 1'b1;
            ST_CLAMP:     o_cmd.clamp     = 1'b1;
            ST_OFF_MUL:   o_cmd.off_mul   = 1'b1;
            ST_OFF_ROUND: o_cmd.off_round = 1'b1;
            ST_STOP:      o_cmd.stop      = 1'b1;
            ST_OUT:       o_cmd.out_load  = w_out_free;
            default:      o_cmd           = '0;
        endcase
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/ats_datapath.sv */
// ----------------------------------------------------------------------------
// ats_datapath
// Registers, shared smoother multiplier, t3 sum, offset and stop arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_datapath
    import ats_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_ats_cmd                    i_cmd,
    output t_ats_status                      o_status,
    // configuration
    input  wire logic                        i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]        i_cfg_data,
    // bar
    input  wire logic [PRICE_W-1:0]          i_bar_high,
    input  wire logic [PRICE_W-1:0]          i_bar_low,
    input  wire logic [PRICE_W-1:0]          i_bar_close,
    input  wire logic                        i_start_series,
    // result
    output logic signed [STOP_W-1:0]         o_long_stop,
    output logic signed [STOP_W-1:0]         o_short_stop,
    output logic                             o_is_short,
    output logic                             o_reversed,
    output logic [PRICE_W-1:0]               o_smoothed_range
);

    localparam logic [PROD_W-1:0]   PROD_RND = PROD_W'(1) << (WEIGHT_W - 1);
    localparam logic [T3_W-1:0]     T3_RND   = T3_W'(1) << (T3_SHIFT - 1);
    localparam logic [OFF_PROD_W:0] OFF_RND  = (OFF_PROD_W + 1)'(1) << (OFF_SHIFT - 1);

    // configuration registers
    logic [WEIGHT_W-1:0]             r_ema_weight;
    logic [FACTOR_W-1:0]             r_range_factor;
    logic                            r_hold;

    // bar state
    logic                            r_dir_short;
    logic [PRICE_W-1:0]              r_best_long;
    logic [PRICE_W-1:0]              r_best_short;
    logic [PRICE_W-1:0]              r_prev_close;
    logic [STAGE_W-1:0]              r_stage [SMOOTH_STAGES];
    logic signed [STOP_W-1:0]        r_prev_long_stop;
    logic signed [STOP_W-1:0]        r_prev_short_stop;

    // working registers
    logic [PRICE_W-1:0]              r_high, r_low, r_close;
    logic                            r_start;
    logic                            r_rev, r_extending;
    logic [STAGE_W-1:0]              r_x;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [T3_W-1:0]          r_t3a, r_t3b, r_num;
    logic [PRICE_W-1:0]              r_rng;
    logic [OFF_PROD_W-1:0]           r_off_prod;
    logic [OFF_W-1:0]                r_off;

    // result registers
    logic signed [STOP_W-1:0]        r_o_long_stop, r_o_short_stop;
    logic                            r_o_is_short, r_o_reversed;
    logic [PRICE_W-1:0]              r_o_range;

    // combinational
    logic signed [PRICE_W+1:0]       w_hl, w_hc, w_cl, w_trmax, w_close_s;
    logic [PRICE_W-1:0]              w_tr, w_tr_start;
    logic signed [DIFF_W-1:0]        w_diff;
    logic signed [WEIGHT_W:0]        w_wt;
    logic [PROD_W-1:0]               w_prod_rnd;
    logic signed [PROD_W-1:0]        w_delta;
    logic [STAGE_W+1:0]              w_acc_sum;
    logic [STAGE_W-1:0]              n_stage;
    logic signed [DIFF_W-1:0]        w_d34;
    logic signed [T3_W-1:0]          w_d34x;
    logic [T3_W-1:0]                 w_num_rnd;
    logic [RNG_WIDE_W-1:0]           w_rng_wide;
    logic [PRICE_W-1:0]              n_rng;
    logic [OFF_PROD_W:0]             w_off_rnd;
    logic signed [SUM_W-1:0]         w_lo, w_hi;
    logic signed [STOP_W-1:0]        n_long_stop, n_short_stop;

    assign o_status.is_start = r_start;

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_weight   <= EMA_WEIGHT_RST;
            r_range_factor <= RANGE_FACTOR_RST;
            r_hold         <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EMA_WEIGHT:   r_ema_weight   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_RANGE_FACTOR: r_range_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_HOLD:         r_hold         <= i_cfg_data[0];
                default:          r_hold         <= r_hold;
            endcase
        end
    end

    // true range against the previous close
    always_comb begin
        w_hl = $signed({2'b00, r_high}) - $signed({2'b00, r_low});
        w_hc = $signed({2'b00, r_high}) - $signed({2'b00, r_prev_close});
        w_cl = $signed({2'b00, r_prev_close}) - $signed({2'b00, r_low});
        w_trmax = w_hl;
        if (w_hc > w_trmax) w_trmax = w_hc;
        if (w_cl > w_trmax) w_trmax = w_cl;
        w_tr       = w_trmax[PRICE_W+1] ? '0 : w_trmax[PRICE_W-1:0];
        w_tr_start = w_hl[PRICE_W+1] ? '0 : w_hl[PRICE_W-1:0];
        w_close_s  = $signed({2'b00, r_close});
    end

    // smoother step: e + round(w * (x - e) / 2^16)
    always_comb begin
        w_diff     = $signed({1'b0, r_x}) - $signed({1'b0, r_stage[0]});
        w_wt       = $signed({1'b0, r_ema_weight});
        w_prod_rnd = r_prod + PROD_RND;
        w_delta    = $signed(w_prod_rnd) >>> WEIGHT_W;
        w_acc_sum  = {2'b00, r_stage[0]} + w_delta[STAGE_W+1:0];
        n_stage    = w_acc_sum[STAGE_W-1:0];
    end

    // t3 terms and clamped, rounded range
    always_comb begin
        w_d34  = $signed({1'b0, r_stage[T3_TAP]}) - $signed({1'b0, r_stage[T3_TAP+1]});
        w_d34x = T3_W'(w_d34);
        w_num_rnd  = {1'b0, r_num[T3_W-2:0]} + T3_RND;
        w_rng_wide = w_num_rnd[T3_W-1:T3_SHIFT];
        if (r_num[T3_W-1] || (r_num == '0)) begin
            n_rng = '0;
        end else if (|w_rng_wide[RNG_WIDE_W-1:PRICE_W]) begin
            n_rng = '1;
        end else begin
            n_rng = w_rng_wide[PRICE_W-1:0];
        end
    end

    // offset rounding and stop sums
    always_comb begin
        w_off_rnd = {1'b0, r_off_prod} + OFF_RND;
        w_lo = $signed({(SUM_W-PRICE_W)'(0), r_best_long}) - $signed({2'b00, r_off})
             + (r_dir_short ? $signed({(SUM_W-PRICE_W)'(0), r_close}) : SUM_W'(0));
        w_hi = $signed({(SUM_W-PRICE_W)'(0), r_best_short}) + $signed({2'b00, r_off})
             + (r_dir_short ? SUM_W'(0) : $signed({(SUM_W-PRICE_W)'(0), r_close}));
        n_long_stop  = sat_stop(w_lo);
        n_short_stop = sat_stop(w_hi);
    end

    // bar state, direction ratchet and smoother stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_short       <= 1'b0;
            r_best_long       <= '0;
            r_best_short      <= '0;
            r_prev_close      <= '0;
            r_prev_long_stop  <= '0;
            r_prev_short_stop <= '0;
            for (int i = 0; i < SMOOTH_STAGES; i++) begin
                r_stage[i] <= '0;
            end
        end else begin
            if (i_cmd.range) begin
                r_prev_close <= r_close;
                if (r_start) begin
                    r_dir_short       <= 1'b0;
                    r_best_long       <= r_close;
                    r_best_short      <= r_close;
                    r_prev_long_stop  <= '0;
                    r_prev_short_stop <= '0;
                    for (int i = 0; i < SMOOTH_STAGES; i++) begin
                        r_stage[i] <= {w_tr_start, {FRAC_EXT{1'b0}}};
                    end
                end else if (!r_dir_short && (w_close_s < r_prev_long_stop)) begin
                    r_dir_short  <= 1'b1;
                    r_best_short <= r_close;
                    r_best_long  <= '0;
                end else if (r_dir_short && (w_close_s > r_prev_short_stop)) begin
                    r_dir_short  <= 1'b0;
                    r_best_long  <= r_close;
                    r_best_short <= '0;
                end else if (!r_dir_short) begin
                    if (r_close > r_best_long) r_best_long <= r_close;
                end else begin
                    if (r_close < r_best_short) r_best_short <= r_close;
                end
            end
            // rotate so the stage being updated is always at the head
            if (i_cmd.acc) begin
                for (int i = 0; i < SMOOTH_STAGES - 1; i++) begin
                    r_stage[i] <= r_stage[i+1];
                end
                r_stage[SMOOTH_STAGES-1] <= n_stage;
            end
            if (i_cmd.stop && !(r_hold && !r_extending)) begin
                r_prev_long_stop  <= n_long_stop;
                r_prev_short_stop <= n_short_stop;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_high  <= i_bar_high;
            r_low   <= i_bar_low;
            r_close <= i_bar_close;
            r_start <= i_start_series;
        end
        if (i_cmd.range) begin
            r_x <= {w_tr, {FRAC_EXT{1'b0}}};
            if (r_start) begin
                r_rev       <= 1'b0;
                r_extending <= 1'b1;
            end else if ((!r_dir_short && (w_close_s < r_prev_long_stop))
                      || (r_dir_short && (w_close_s > r_prev_short_stop))) begin
                r_rev       <= 1'b1;
                r_extending <= 1'b1;
            end else begin
                r_rev       <= 1'b0;
                r_extending <= r_dir_short ? (r_close < r_best_short)
                                           : (r_close > r_best_long);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= w_wt * w_diff;
        end
        if (i_cmd.acc) begin
            r_x <= n_stage;
        end
        if (i_cmd.t3_diff) begin
            r_t3a <= w_d34x * $signed(T3_W'(T3_K_OUTER));
            r_t3b <= $signed(T3_W'(r_stage[T3_TAP+2])) * $signed(T3_W'(T3_K_INNER))
                   - $signed(T3_W'(r_stage[T3_TAP+3]));
        end
        if (i_cmd.t3_sum) begin
            r_num <= r_t3a + r_t3b;
        end
        if (i_cmd.clamp) begin
            r_rng <= n_rng;
        end
        if (i_cmd.off_mul) begin
            r_off_prod <= r_rng * r_range_factor;
        end
        if (i_cmd.off_round) begin
            r_off <= w_off_rnd[OFF_PROD_W:OFF_SHIFT];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_long_stop  <= r_prev_long_stop;
            r_o_short_stop <= r_prev_short_stop;
            r_o_is_short   <= r_dir_short;
            r_o_reversed   <= r_rev;
            r_o_range      <= r_rng;
        end
    end

    assign o_long_stop      = r_o_long_stop;
    assign o_short_stop     = r_o_short_stop;
    assign o_is_short       = r_o_is_short;
    assign o_reversed       = r_o_reversed;
    assign o_smoothed_range = r_o_range;

endmodule

`default_nettype wire

/* src/atr_ratchet_trailing_stop_core.sv */
// ----------------------------------------------------------------------------
// atr_ratchet_trailing_stop_core
// T3-smoothed true-range trailing stop with long/short direction ratchet.
// ----------------------------------------------------------------------------
// One price bar is taken per transaction and gives one result. A bar is
// accepted only in the idle state, once the last result is in the output
// register; a start bar skips the smoother steps and the offset and stop
// states. The time per bar is set by the six smoother stages sharing one
// 17x41 multiplier, each stage taking a multiply and an accumulate step,
// then the t3 states (difference, sum, clamp) and the offset and stop states
// (multiply, round, stop). A finished result sits in an output register, so
// the next bar is accepted while that result waits. Configuration writes are
// always ready and must be made only while no bar is in flight.
`default_nettype none

module atr_ratchet_trailing_stop_core
    import ats_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   i_cfg_data,
    // bar input
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [PRICE_W-1:0]     i_bar_high,
    input  wire logic [PRICE_W-1:0]     i_bar_low,
    input  wire logic [PRICE_W-1:0]     i_bar_close,
    input  wire logic                   i_start_series,
    // result output
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [STOP_W-1:0]    o_long_stop,
    output logic signed [STOP_W-1:0]    o_short_stop,
    output logic                        o_is_short,
    output logic                        o_reversed,
    output logic [PRICE_W-1:0]          o_smoothed_range
);

    t_ats_cmd    w_cmd;
    t_ats_status w_status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ats_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    ats_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_bar_high       (i_bar_high),
        .i_bar_low        (i_bar_low),
        .i_bar_close      (i_bar_close),
        .i_start_series   (i_start_series),
        .o_long_stop      (o_long_stop),
        .o_short_stop     (o_short_stop),
        .o_is_short       (o_is_short),
        .o_reversed       (o_reversed),
        .o_smoothed_range (o_smoothed_range)
    );

endmodule

`default_nettype wire

/* src/ats_checker.sv */
// ----------------------------------------------------------------------------
// ats_checker
// Port-level checks on the trailing stop core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_checker
    import ats_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [STOP_W-1:0]    o_long_stop,
    input wire logic [STOP_W-1:0]    o_short_stop,
    input wire logic [PRICE_W-1:0]   o_smoothed_range
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_long_stop) && $stable(o_short_stop)
                                        && $stable(o_smoothed_range))
        else $error("stalled result changed");

    // one bar at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // a new result is only produced while a bar is being worked on
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no bar in flight");

endmodule

bind atr_ratchet_trailing_stop_core ats_checker u_ats_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_long_stop      (o_long_stop),
    .o_short_stop     (o_short_stop),
    .o_smoothed_range (o_smoothed_range)
);

`default_nettype wire

/* bench/ats_stop_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ats_stop_checker
// Watches the configuration, bar and result channels of the trailing stop
// core. Every accepted bar goes through a local copy of the smoother chain,
// the t3 combination and the stop ratchet. The expected stop levels wait in
// order, and each accepted result is compared with the oldest one, field by
// field.
// ----------------------------------------------------------------------------

module ats_stop_checker
    import ats_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration channel
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DAT_W-1:0]      i_cfg_data,
    // bar channel
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [PRICE_W-1:0]        i_bar_high,
    input  logic [PRICE_W-1:0]        i_bar_low,
    input  logic [PRICE_W-1:0]        i_bar_close,
    input  logic                      i_start_series,
    // result channel
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [STOP_W-1:0]  i_long_stop,
    input  logic signed [STOP_W-1:0]  i_short_stop,
    input  logic                      i_is_short,
    input  logic                      i_reversed,
    input  logic [PRICE_W-1:0]        i_smoothed_range,
    // to the bench top
    output int                        o_fail_count,
    output int                        o_outstanding
);

    typedef struct packed {
        logic signed [STOP_W-1:0] long_stop;
        logic signed [STOP_W-1:0] short_stop;
        logic                     is_short;
        logic                     reversed;
        logic [PRICE_W-1:0]       smoothed_range;
    } t_stop_levels;

    localparam longint LEVEL_MAX = (longint'(1) <<< (STOP_W - 1)) - 1;
    localparam longint LEVEL_MIN = -(longint'(1) <<< (STOP_W - 1));

    // register copies
    logic [WEIGHT_W-1:0]      weight_q;
    logic [FACTOR_W-1:0]      factor_q;
    logic                     hold_q;

    // ratchet and smoother state
    logic                     going_short;
    logic [PRICE_W-1:0]       peak_long;
    logic [PRICE_W-1:0]       trough_short;
    logic [PRICE_W-1:0]       last_close;
    logic [STAGE_W-1:0]       ema_chain [SMOOTH_STAGES];
    logic signed [STOP_W-1:0] long_level;
    logic signed [STOP_W-1:0] short_level;

    t_stop_levels             stop_levels_due[$];

    // one exponential smoother step, rounded
    function automatic logic [STAGE_W-1:0] ema_next(input logic [STAGE_W-1:0] x,
                                                    input logic [STAGE_W-1:0] e,
                                                    input logic [WEIGHT_W-1:0] w);
        logic [63:0] acc;
        acc = 64'(w) * 64'(x) + (64'd65536 - 64'(w)) * 64'(e) + 64'd32768;
        return acc[STAGE_W+15:16];
    endfunction

    // t3 of stages 3..6 with b = 0.5, scaled by 8, back to Q24.8
    function automatic logic [PRICE_W-1:0] t3_range();
        longint      num;
        logic [63:0] sum;
        num = 27 * longint'(ema_chain[2]) - 27 * longint'(ema_chain[3])
            + 9 * longint'(ema_chain[4]) - longint'(ema_chain[5]);
        if (num <= 0) begin
            return '0;
        end
        sum = (64'(num) + 64'd1024) >> 11;
        if (sum > 64'hFFFF_FFFF) begin
            return '1;
        end
        return sum[PRICE_W-1:0];
    endfunction

    function automatic logic signed [STOP_W-1:0] clamp_level(input longint v);
        if (v > LEVEL_MAX) begin
            return LEVEL_MAX[STOP_W-1:0];
        end else if (v < LEVEL_MIN) begin
            return LEVEL_MIN[STOP_W-1:0];
        end
        return v[STOP_W-1:0];
    endfunction

    // advance the ratchet by one bar and give its stop levels
    function automatic t_stop_levels step_trailing_stop(input logic [PRICE_W-1:0] h,
                                                        input logic [PRICE_W-1:0] l,
                                                        input logic [PRICE_W-1:0] c,
                                                        input logic s);
        t_stop_levels       r;
        longint             tr;
        longint             lo;
        longint             hi;
        logic [STAGE_W-1:0] x;
        logic [63:0]        off;
        logic [PRICE_W-1:0] rng;
        logic               flipped;
        logic               extending;
        int                 i;
        flipped   = 1'b0;
        extending = 1'b1;
        if (s) begin
            // seed every stage with the bar's own range
            tr = (h >= l) ? longint'(h) - longint'(l) : 0;
            x  = {tr[PRICE_W-1:0], {FRAC_EXT{1'b0}}};
            for (i = 0; i < SMOOTH_STAGES; i++) begin
                ema_chain[i] = x;
            end
            going_short  = 1'b0;
            peak_long    = c;
            trough_short = c;
            last_close   = c;
            long_level   = '0;
            short_level  = '0;
            rng          = t3_range();
        end else begin
            // true range against the previous close, never negative
            tr = longint'(h) - longint'(l);
            if (longint'(h) - longint'(last_close) > tr) begin
                tr = longint'(h) - longint'(last_close);
            end
            if (longint'(last_close) - longint'(l) > tr) begin
                tr = longint'(last_close) - longint'(l);
            end
            if (tr < 0) begin
                tr = 0;
            end
            x = {tr[PRICE_W-1:0], {FRAC_EXT{1'b0}}};
            for (i = 0; i < SMOOTH_STAGES; i++) begin
                ema_chain[i] = ema_next(x, ema_chain[i], weight_q);
                x = ema_chain[i];
            end
            rng = t3_range();
            off = (64'(rng) * 64'(factor_q) + 64'd2048) >> 12;

            // direction ratchet
            if (!going_short && longint'(c) < longint'(long_level)) begin
                going_short  = 1'b1;
                trough_short = c;
                peak_long    = '0;
                flipped      = 1'b1;
            end else if (going_short && longint'(c) > longint'(short_level)) begin
                going_short  = 1'b0;
                peak_long    = c;
                trough_short = '0;
                flipped      = 1'b1;
            end else if (!going_short) begin
                if (c > peak_long) begin
                    peak_long = c;
                end else begin
                    extending = 1'b0;
                end
            end else begin
                if (c < trough_short) begin
                    trough_short = c;
                end else begin
                    extending = 1'b0;
                end
            end

            // new stop levels unless held on a non-extending bar
            if (!(hold_q && !extending)) begin
                lo = longint'(peak_long) - longint'(off);
                hi = longint'(trough_short) + longint'(off);
                if (going_short) begin
                    lo += longint'(c);
                end else begin
                    hi += longint'(c);
                end
                long_level  = clamp_level(lo);
                short_level = clamp_level(hi);
            end
            last_close = c;
        end
        r.long_stop      = long_level;
        r.short_stop     = short_level;
        r.is_short       = going_short;
        r.reversed       = flipped;
        r.smoothed_range = rng;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // channel monitor: results are checked before new bars are queued
    always @(posedge i_clk) begin
        t_stop_levels want;
        if (!i_rst_n) begin
            weight_q     = EMA_WEIGHT_RST;
            factor_q     = RANGE_FACTOR_RST;
            hold_q       = 1'b0;
            going_short  = 1'b0;
            peak_long    = '0;
            trough_short = '0;
            last_close   = '0;
            for (int i = 0; i < SMOOTH_STAGES; i++) begin
                ema_chain[i] = '0;
            end
            long_level   = '0;
            short_level  = '0;
            stop_levels_due.delete();
            o_fail_count  = 0;
            o_outstanding = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EMA_WEIGHT: begin
                        weight_q = i_cfg_data[WEIGHT_W-1:0];
                    end
                    CFG_RANGE_FACTOR: begin
                        factor_q = i_cfg_data[FACTOR_W-1:0];
                    end
                    CFG_HOLD: begin
                        hold_q = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (stop_levels_due.size() == 0) begin
                    $error("result transaction with no bar outstanding");
                    o_fail_count++;
                end else begin
                    want = stop_levels_due.pop_front();
                    check_field("long_stop", want.long_stop, i_long_stop);
                    check_field("short_stop", want.short_stop, i_short_stop);
                    check_field("is_short", want.is_short, i_is_short);
                    check_field("reversed", want.reversed, i_reversed);
                    check_field("smoothed_range", want.smoothed_range, i_smoothed_range);
                end
            end
            if (i_in_valid && i_in_ready) begin
                stop_levels_due.push_back(step_trailing_stop(i_bar_high, i_bar_low,
                                                             i_bar_close, i_start_series));
            end
            o_outstanding = stop_levels_due.size();
        end
    end

endmodule

/* bench/tb_atr_ratchet_trailing_stop_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_atr_ratchet_trailing_stop_core
// Bench for the trailing stop core: a short run of hand-picked bars, then
// random price series with trends, jumps and reversals mixed with noise bars,
// under several register settings, with random gaps on the bar channel and
// random stalls on the result channel. The checker beside the core does the
// prediction and comparison.
// ----------------------------------------------------------------------------

module tb_atr_ratchet_trailing_stop_core;
    import ats_pkg::*;

    localparam int LIMIT = 400000;
    localparam int TAIL  = 30;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DAT_W-1:0]     i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [PRICE_W-1:0]       i_bar_high;
    logic [PRICE_W-1:0]       i_bar_low;
    logic [PRICE_W-1:0]       i_bar_close;
    logic                     i_start_series;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [STOP_W-1:0] o_long_stop;
    logic signed [STOP_W-1:0] o_short_stop;
    logic                     o_is_short;
    logic                     o_reversed;
    logic [PRICE_W-1:0]       o_smoothed_range;

    int                       fail_count;
    int                       outstanding;
    int                       cycle_count = 0;
    bit                       gaps_on = 1'b1;

    always #6 i_clk = ~i_clk;

    atr_ratchet_trailing_stop_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_bar_high       (i_bar_high),
        .i_bar_low        (i_bar_low),
        .i_bar_close      (i_bar_close),
        .i_start_series   (i_start_series),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_long_stop      (o_long_stop),
        .o_short_stop     (o_short_stop),
        .o_is_short       (o_is_short),
        .o_reversed       (o_reversed),
        .o_smoothed_range (o_smoothed_range)
    );

    ats_stop_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_bar_high       (i_bar_high),
        .i_bar_low        (i_bar_low),
        .i_bar_close      (i_bar_close),
        .i_start_series   (i_start_series),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_long_stop      (o_long_stop),
        .i_short_stop     (o_short_stop),
        .i_is_short       (o_is_short),
        .i_reversed       (o_reversed),
        .i_smoothed_range (o_smoothed_range),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // whole price units to Q24.8
    function automatic logic [PRICE_W-1:0] px(input int units);
        return PRICE_W'(units) << 8;
    endfunction

    function automatic logic [PRICE_W-1:0] clamp_price(input longint v);
        if (v < 0) begin
            return '0;
        end else if (v > longint'(64'hFFFF_FFFF)) begin
            return '1;
        end
        return v[PRICE_W-1:0];
    endfunction

    // one bar transaction, sometimes with a random gap ahead of it
    task automatic send_bar(input logic [PRICE_W-1:0] h, input logic [PRICE_W-1:0] l,
                            input logic [PRICE_W-1:0] c, input logic s);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_bar_high     <= h;
        i_bar_low      <= l;
        i_bar_close    <= c;
        i_start_series <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // register write; the caller drops valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] f,
                             input logic [CFG_DAT_W-1:0] hold_word);
        write_reg(CFG_EMA_WEIGHT, w);
        write_reg(CFG_RANGE_FACTOR, f);
        write_reg(CFG_HOLD, hold_word);
        write_reg(CFG_UNMAPPED, CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every result is back, then let the core settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (TAIL) @(posedge i_clk);
    endtask

    // start, extend, stall, drop into short, extend short, then flip back long
    task automatic run_swing();
        send_bar(px(102), px(100), px(101), 1'b1);
        send_bar(px(104), px(101), px(103), 1'b0);
        send_bar(px(103), px(102), px(102), 1'b0);
        send_bar(px(102), px(80), px(80), 1'b0);
        send_bar(px(81), px(78), px(78), 1'b0);
        send_bar(px(82), px(79), px(81), 1'b0);
        send_bar(px(120), px(90), px(120), 1'b0);
    endtask

    // trending random walk opened by a start bar
    task automatic run_series(input int n_bars);
        longint mid;
        longint step;
        longint vol;
        int     trend;
        int     k;
        case ($urandom_range(0, 3))
            0: begin
                mid = longint'(px($urandom_range(20, 5000)));
                vol = $urandom_range(16, 4096);
            end
            1: begin
                mid = longint'($urandom);
                vol = $urandom_range(256, 1 << 20);
            end
            2: begin
                mid = longint'(64'hFFFF_FFFF) - longint'($urandom_range(0, 1 << 16));
                vol = $urandom_range(256, 1 << 18);
            end
            default: begin
                mid = longint'($urandom_range(0, 1024));
                vol = $urandom_range(1, 256);
            end
        endcase
        trend = ($urandom_range(0, 1) == 1) ? 1 : -1;
        for (k = 0; k < n_bars; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                trend = -trend;
            end
            step = trend * longint'($urandom_range(0, vol))
                 + longint'($urandom_range(0, vol)) - vol / 2;
            // occasional gap move to force crossings
            if ($urandom_range(0, 9) == 0) begin
                step = step * 8;
            end
            mid = longint'(clamp_price(mid + step));
            send_bar(clamp_price(mid + longint'($urandom_range(0, vol))),
                     clamp_price(mid - longint'($urandom_range(0, vol))),
                     mid[PRICE_W-1:0], k == 0);
        end
    endtask

    // unstructured bars, malformed ones and stray starts included
    task automatic run_noise(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_bar($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(5, 40);
                run_series(len);
            end else begin
                len = $urandom_range(1, 4);
                run_noise(len);
            end
            sent += len;
            if (gaps_on && $urandom_range(0, 15) == 0) begin
                wait_drained();
            end
        end
    endtask

    // result side stalls in bursts
    initial begin
        i_out_ready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (gaps_on) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_bar_high     <= '0;
        i_bar_low      <= '0;
        i_bar_close    <= '0;
        i_start_series <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hand-picked bars under reset settings, first one before any start
        send_bar(px(100), px(98), px(99), 1'b0);
        run_swing();
        send_bar(px(100), px(110), px(105), 1'b0);
        send_bar(px(50), px(60), px(55), 1'b1);
        send_bar('1, '0, '1, 1'b1);
        send_bar('1, '0, '0, 1'b0);
        send_bar('0, '0, '0, 1'b0);
        send_bar('1, '1, '1, 1'b0);
        send_bar('0, '1, '1, 1'b0);
        send_bar('0, '0, '0, 1'b1);
        wait_drained();

        // fastest smoother, zero offset, hold on
        configure(16'hFFFF, 16'h0000, 16'h0001);
        run_swing();
        run_phase(150);
        wait_drained();

        // slowest smoother, largest factor, hold off
        configure(16'h0001, 16'hFFFF, 16'hFFFE);
        run_phase(150);
        wait_drained();

        // frozen smoother
        configure(16'h0000, 16'd40000, 16'h0001);
        run_phase(60);
        wait_drained();

        configure(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
        run_phase(200);
        wait_drained();

        configure(EMA_WEIGHT_RST, RANGE_FACTOR_RST, 16'h0001);
        run_phase(200);
        gaps_on = 1'b0;
        wait_drained();

        // last stretch at full rate on both sides
        configure(CFG_DAT_W'($urandom_range(1, 65535)), CFG_DAT_W'($urandom),
                  CFG_DAT_W'($urandom));
        run_phase(240);
        wait_drained();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
